[hw/rtl/csc_pkg.sv]
// Package: shared types, constants and calendar helper functions for the seconds converter
`timescale 1ns / 1ps

package csc_pkg;

    localparam logic [11:0] FIRST_YEAR    = 12'd2000;
    localparam logic [11:0] LAST_YEAR     = 12'd2100;
    // Offset of 2100 from 2000, the only century year in reach that is not a leap year
    localparam logic [7:0]  CENTURY_OFF   = 8'd100;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    // Reciprocals for exact floor division over the operand widths used
    localparam logic [25:0] DAY_RECIP  = 26'd50903317; // (t >> 7) / 675, shift 35
    localparam logic [18:0] YEAR_RECIP = 19'd367469;   // (4 * days) / 1461, shift 29
    localparam logic [15:0] MIN_RECIP  = 16'd34953;    // (rem >> 2) / 15, shift 19
    localparam logic [9:0]  HOUR_RECIP = 10'd547;      // (mt >> 2) / 15, shift 13

    typedef enum logic [2:0] {
        ST_OK,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_SECOND
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] seconds;
    } in_item_t;

    typedef struct packed {
        logic        mode;
        status_t     status;
        logic [7:0]  yoff;
        logic [8:0]  doy;
        logic [16:0] hms;
        logic [15:0] days;
        logic [16:0] t_low;
    } s1_t;

    typedef struct packed {
        logic        mode;
        status_t     status;
        logic [15:0] days;
        logic [16:0] hms;
        logic [16:0] rem;
        logic [7:0]  est;
    } s2_t;

    typedef struct packed {
        logic        mode;
        status_t     status;
        logic [31:0] secs;
        logic [7:0]  yoff;
        logic [8:0]  doy;
        logic [10:0] mt;
        logic [16:0] rem;
    } s3_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] seconds;
    } out_item_t;

    // Leap test for years 2000..2199 given as offset from 2000
    function automatic logic is_leap(input logic [7:0] yoff);
        return (yoff[1:0] == 2'b00) && (yoff != CENTURY_OFF);
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
        logic [4:0] len;
        unique case (idx)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the year before the first of month idx (0 = January)
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Days from 2000-01-01 to January 1 of year 2000 + yoff
    function automatic logic [15:0] days_before(input logic [7:0] yoff);
        logic [15:0] base;
        logic [8:0]  q;
        q    = {1'b0, yoff} + 9'd3;
        base = {8'd0, yoff} * {7'd0, DAYS_PER_YEAR};
        base = base + {9'd0, q[8:2]};
        if (yoff > CENTURY_OFF) begin
            base = base - 16'd1;
        end
        return base;
    endfunction

endpackage

[hw/rtl/calendar_seconds_converter.sv]
// Top level: calendar date/time to and from seconds since 2000-01-01, four-stage pipeline
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_mode, s_in_year .. s_in_second, s_in_seconds
// m_        out        m_valid / m_ready  m_status, m_out_year .. m_out_second, m_out_seconds
//
// Each transfer passes every stage register to m_, one per cycle while m_ready is high.
// The depth is set by the seconds path: a reciprocal multiply for the day count,
// then one for the year estimate, then the minute and hour splits, one per stage.
// Reset (aresetn low at a clock edge) clears the stage valid bits only.
// A stalled stage holds its item; empty stages upstream keep filling, so
// s_ready drops only once every stage holds an item.

module calendar_seconds_converter
    import csc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [11:0] s_in_year,
    input  logic [3:0]  s_in_month,
    input  logic [4:0]  s_in_day,
    input  logic [4:0]  s_in_hour,
    input  logic [5:0]  s_in_minute,
    input  logic [5:0]  s_in_second,
    input  logic [31:0] s_in_seconds,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [11:0] m_out_year,
    output logic [3:0]  m_out_month,
    output logic [4:0]  m_out_day,
    output logic [4:0]  m_out_hour,
    output logic [5:0]  m_out_minute,
    output logic [5:0]  m_out_second,
    output logic [31:0] m_out_seconds
);

    in_item_t  in_item;
    s1_t       s1_data;
    s2_t       s2_data;
    s3_t       s3_data;
    out_item_t out_item;
    logic      s1_valid, s1_ready;
    logic      s2_valid, s2_ready;
    logic      s3_valid, s3_ready;

    // Gather the input transfer into one bundle
    assign in_item.mode    = s_mode;
    assign in_item.year    = s_in_year;
    assign in_item.month   = s_in_month;
    assign in_item.day     = s_in_day;
    assign in_item.hour    = s_in_hour;
    assign in_item.minute  = s_in_minute;
    assign in_item.second  = s_in_second;
    assign in_item.seconds = s_in_seconds;

    // Stage 1: validate date fields, or split seconds into whole days
    csc_check_split u_check_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (in_item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage 2: total days since 2000, or remainder seconds and year estimate
    csc_day_count u_day_count (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: seconds total, or settle the year and count minutes of the day
    csc_year_find u_year_find (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Stage 4: month and day, hour/minute/second, result register
    csc_assemble u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_item)
    );

    assign m_status      = out_item.status;
    assign m_out_year    = out_item.year;
    assign m_out_month   = out_item.month;
    assign m_out_day     = out_item.day;
    assign m_out_hour    = out_item.hour;
    assign m_out_minute  = out_item.minute;
    assign m_out_second  = out_item.second;
    assign m_out_seconds = out_item.seconds;

    // A failed check never carries a seconds count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_out_seconds == 32'd0))
        else $error("seconds count on a failed result");

    // Date results and seconds results are never mixed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_seconds != 32'd0) |-> (m_out_year == 12'd0))
        else $error("date fields set on a seconds result");

    // A computed date lies in a real month and starts at day one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_year != 12'd0) |->
            (m_out_month >= 4'd1) && (m_out_month <= 4'd12) && (m_out_day >= 5'd1)
            && (m_out_year >= FIRST_YEAR))
        else $error("computed date out of shape");

    // The time split stays within a day
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_year != 12'd0) |->
            (m_out_hour <= 5'd23) && (m_out_minute <= 6'd59) && (m_out_second <= 6'd59))
        else $error("computed time out of range");

endmodule

[hw/rtl/csc_check_split.sv]
// Stage 1: field checks and day-of-year for dates, day split of a seconds count
`timescale 1ns / 1ps

module csc_check_split
    import csc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output s1_t      out_data
);

    logic        valid_reg;
    s1_t         data_reg;
    s1_t         data_next;
    logic [11:0] yoff_full;
    logic        leap;
    logic [3:0]  midx;
    logic [50:0] day_prod;
    status_t     status;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        yoff_full = in_data.year - FIRST_YEAR;
        leap      = is_leap(yoff_full[7:0]);
        midx      = in_data.month - 4'd1;

        // First failing check wins
        if ((in_data.year < FIRST_YEAR) || (in_data.year > LAST_YEAR)) begin
            status = ST_YEAR;
        end else if ((in_data.month < 4'd1) || (in_data.month > 4'd12)) begin
            status = ST_MONTH;
        end else if ((in_data.day < 5'd1) || (in_data.day > month_len(leap, midx))) begin
            status = ST_DAY;
        end else if (in_data.hour > 5'd23) begin
            status = ST_HOUR;
        end else if (in_data.minute > 6'd59) begin
            status = ST_MINUTE;
        end else if (in_data.second > 6'd59) begin
            status = ST_SECOND;
        end else begin
            status = ST_OK;
        end

        day_prod = 51'(in_data.seconds[31:7]) * 51'(DAY_RECIP);

        data_next.mode   = in_data.mode;
        data_next.status = in_data.mode ? ST_OK : status;
        data_next.yoff   = yoff_full[7:0];
        data_next.doy    = month_start(leap, midx) + {4'd0, in_data.day} - 9'd1;
        data_next.hms    = {11'd0, in_data.second}
                         + ({11'd0, in_data.minute} * {11'd0, SECS_PER_MIN})
                         + ({12'd0, in_data.hour} * {5'd0, SECS_PER_HOUR});
        data_next.days   = day_prod[50:35];
        data_next.t_low  = in_data.seconds[16:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/csc_day_count.sv]
// Stage 2: total day count for dates, remainder and year estimate for seconds
`timescale 1ns / 1ps

module csc_day_count
    import csc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic        valid_reg;
    s2_t         data_reg;
    s2_t         data_next;
    logic [32:0] day_secs;
    logic [34:0] est_prod;
    logic [15:0] total;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        total    = days_before(in_data.yoff) + {7'd0, in_data.doy};
        day_secs = 33'(in_data.days) * 33'(SECS_PER_DAY);
        // Estimate on the plain four-year cycle; may run one year low past 2100
        est_prod = 35'(in_data.days) * 35'(YEAR_RECIP);

        data_next.mode   = in_data.mode;
        data_next.status = in_data.status;
        data_next.days   = in_data.mode ? in_data.days : total;
        data_next.hms    = in_data.hms;
        data_next.rem    = in_data.t_low - day_secs[16:0];
        data_next.est    = est_prod[34:27];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/csc_year_find.sv]
// Stage 3: seconds total for dates, year fix-up and minute count for seconds
`timescale 1ns / 1ps

module csc_year_find
    import csc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic        valid_reg;
    s3_t         data_reg;
    s3_t         data_next;
    logic [32:0] sec_prod;
    logic [15:0] db;
    logic [8:0]  diff;
    logic [8:0]  year_days;
    logic [7:0]  next_yoff;
    logic [30:0] mt_prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        sec_prod  = 33'(in_data.days) * 33'(SECS_PER_DAY);
        db        = days_before(in_data.est);
        diff      = 9'(in_data.days - db);
        year_days = DAYS_PER_YEAR + {8'd0, is_leap(in_data.est)};
        next_yoff = in_data.est + 8'd1;
        mt_prod   = 31'(in_data.rem[16:2]) * 31'(MIN_RECIP);

        data_next.mode   = in_data.mode;
        data_next.status = in_data.status;
        if (!in_data.mode && (in_data.status == ST_OK)) begin
            data_next.secs = sec_prod[31:0] + {15'd0, in_data.hms};
        end else begin
            data_next.secs = 32'd0;
        end
        // Advance one year when the estimate falls short
        if (diff >= year_days) begin
            data_next.yoff = next_yoff;
            data_next.doy  = diff - year_days;
        end else begin
            data_next.yoff = in_data.est;
            data_next.doy  = diff;
        end
        data_next.mt  = mt_prod[29:19];
        data_next.rem = in_data.rem;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/csc_assemble.sv]
// Stage 4: month search, hour/minute/second split and result register
`timescale 1ns / 1ps

module csc_assemble
    import csc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  s3_t       in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic        valid_reg;
    out_item_t   data_reg;
    out_item_t   data_next;
    logic        leap;
    logic [3:0]  midx;
    logic [8:0]  dom;
    logic [18:0] hr_prod;
    logic [4:0]  hour;
    logic [10:0] min_full;
    logic [16:0] sec_full;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        leap = is_leap(in_data.yoff);
        midx = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (in_data.doy >= month_start(leap, 4'(k))) begin
                midx = midx + 4'd1;
            end
        end
        dom      = in_data.doy - month_start(leap, midx) + 9'd1;
        hr_prod  = 19'(in_data.mt[10:2]) * 19'(HOUR_RECIP);
        hour     = hr_prod[17:13];
        min_full = in_data.mt - ({6'd0, hour} * {5'd0, SECS_PER_MIN});
        sec_full = in_data.rem - ({6'd0, in_data.mt} * {11'd0, SECS_PER_MIN});

        if (in_data.mode) begin
            data_next.status  = (in_data.yoff > CENTURY_OFF) ? ST_YEAR : ST_OK;
            data_next.year    = FIRST_YEAR + {4'd0, in_data.yoff};
            data_next.month   = midx + 4'd1;
            data_next.day     = dom[4:0];
            data_next.hour    = hour;
            data_next.minute  = min_full[5:0];
            data_next.second  = sec_full[5:0];
            data_next.seconds = 32'd0;
        end else begin
            data_next.status  = in_data.status;
            data_next.year    = 12'd0;
            data_next.month   = 4'd0;
            data_next.day     = 5'd0;
            data_next.hour    = 5'd0;
            data_next.minute  = 6'd0;
            data_next.second  = 6'd0;
            data_next.seconds = in_data.secs;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[tb/sv/csc_checker.sv]
// Checker for the calendar seconds converter: predicts every result and compares it
`timescale 1ns / 1ps

module csc_checker
    import csc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [11:0] s_in_year,
    input  logic [3:0]  s_in_month,
    input  logic [4:0]  s_in_day,
    input  logic [4:0]  s_in_hour,
    input  logic [5:0]  s_in_minute,
    input  logic [5:0]  s_in_second,
    input  logic [31:0] s_in_seconds,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [11:0] m_out_year,
    input  logic [3:0]  m_out_month,
    input  logic [4:0]  m_out_day,
    input  logic [4:0]  m_out_hour,
    input  logic [5:0]  m_out_minute,
    input  logic [5:0]  m_out_second,
    input  logic [31:0] m_out_seconds,

    output int          mismatches,
    output int          outstanding,
    output int          compared
);

    localparam int unsigned DAY_SECS  = 86400;
    localparam int unsigned HOUR_SECS = 3600;
    localparam int unsigned MIN_SECS  = 60;

    out_item_t expected_times[$];
    int        err_total = 0;
    int        n_compared = 0;

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned mo);
        int unsigned len;
        case (mo)
            4, 6, 9, 11: len = 30;
            2:           len = leap_year(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic int unsigned year_length(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    // First failing field wins, in year, month, day, hour, minute, second order
    function automatic status_t check_date(input int unsigned y, input int unsigned mo,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
        status_t st;
        if (y < FIRST_YEAR || y > LAST_YEAR) begin
            st = ST_YEAR;
        end else if (mo < 1 || mo > 12) begin
            st = ST_MONTH;
        end else if (d < 1 || d > month_length(y, mo)) begin
            st = ST_DAY;
        end else if (h > 23) begin
            st = ST_HOUR;
        end else if (mi > 59) begin
            st = ST_MINUTE;
        end else if (s > 59) begin
            st = ST_SECOND;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    function automatic out_item_t convert_calendar(input in_item_t it);
        out_item_t   r;
        int unsigned days;
        int unsigned rest;
        int unsigned y;
        int unsigned mo;
        r = '0;
        if (!it.mode) begin
            r.status = check_date(it.year, it.month, it.day, it.hour, it.minute, it.second);
            if (r.status == ST_OK) begin
                days = int'(it.day) - 1;
                for (mo = 1; mo < it.month; mo++) begin
                    days += month_length(it.year, mo);
                end
                for (y = FIRST_YEAR; y < it.year; y++) begin
                    days += year_length(y);
                end
                r.seconds = it.second + it.minute * MIN_SECS + it.hour * HOUR_SECS
                          + days * DAY_SECS;
            end
        end else begin
            days     = it.seconds / DAY_SECS;
            rest     = it.seconds % DAY_SECS;
            r.hour   = 5'(rest / HOUR_SECS);
            rest     = rest % HOUR_SECS;
            r.minute = 6'(rest / MIN_SECS);
            r.second = 6'(rest % MIN_SECS);
            y = FIRST_YEAR;
            while (days >= year_length(y)) begin
                days -= year_length(y);
                y++;
            end
            mo = 1;
            while (mo < 12 && days >= month_length(y, mo)) begin
                days -= month_length(y, mo);
                mo++;
            end
            r.year   = 12'(y);
            r.month  = 4'(mo);
            r.day    = 5'(days + 1);
            r.status = check_date(y, mo, days + 1, r.hour, r.minute, r.second);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            err_total++;
            $display("%0t: %s mismatch on result %0d, expected %0d, actual %0d",
                     $time, name, n_compared, want, got);
        end
    endtask

    always @(posedge aclk) begin
        in_item_t  item;
        out_item_t want;
        if (!aresetn) begin
            expected_times.delete();
        end else begin
            if (s_valid && s_ready) begin
                item.mode    = s_mode;
                item.year    = s_in_year;
                item.month   = s_in_month;
                item.day     = s_in_day;
                item.hour    = s_in_hour;
                item.minute  = s_in_minute;
                item.second  = s_in_second;
                item.seconds = s_in_seconds;
                expected_times.push_back(convert_calendar(item));
            end
            if (m_valid && m_ready) begin
                if (expected_times.size() == 0) begin
                    err_total++;
                    $display("%0t: result with none expected, expected nothing, actual status %0d",
                             $time, m_status);
                end else begin
                    want = expected_times.pop_front();
                    compare_field("status",  32'(want.status),  32'(m_status));
                    compare_field("year",    32'(want.year),    32'(m_out_year));
                    compare_field("month",   32'(want.month),   32'(m_out_month));
                    compare_field("day",     32'(want.day),     32'(m_out_day));
                    compare_field("hour",    32'(want.hour),    32'(m_out_hour));
                    compare_field("minute",  32'(want.minute),  32'(m_out_minute));
                    compare_field("second",  32'(want.second),  32'(m_out_second));
                    compare_field("seconds", want.seconds,      m_out_seconds);
                    n_compared++;
                end
            end
        end
        mismatches  <= err_total;
        outstanding <= expected_times.size();
        compared    <= n_compared;
    end

endmodule

[tb/sv/tb.sv]
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the seconds converter
`timescale 1ns / 1ps

module tb;
    import csc_pkg::*;

    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // Long receiver hold-off, well past the four pipeline stages
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 320;
    // Settle time after the last result
    localparam int DRAIN_CYCLES = 16;
    // Last count that still lands on 2100-12-31 23:59:59
    localparam logic [31:0] LAST_VALID_SECS = 32'd3187295999;

    typedef enum int {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH_LIGHT
    } idle_phase_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_mode       = 1'b0;
    logic [11:0] s_in_year    = '0;
    logic [3:0]  s_in_month   = '0;
    logic [4:0]  s_in_day     = '0;
    logic [4:0]  s_in_hour    = '0;
    logic [5:0]  s_in_minute  = '0;
    logic [5:0]  s_in_second  = '0;
    logic [31:0] s_in_seconds = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [2:0]  m_status;
    logic [11:0] m_out_year;
    logic [3:0]  m_out_month;
    logic [4:0]  m_out_day;
    logic [4:0]  m_out_hour;
    logic [5:0]  m_out_minute;
    logic [5:0]  m_out_second;
    logic [31:0] m_out_seconds;

    int mismatches;
    int pending_results;
    int results_checked;

    // Receiver control: stall percentage and hold-off requests come from the
    // stimulus process by nonblocking update; the receiver counts its own hold.
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    // Sender gap percentage, read and written only by the stimulus process
    int sender_idle_pct = 0;
    int n_to_seconds    = 0;
    int n_to_date       = 0;
    int idle_cycles     = 0;

    always #5 aclk = ~aclk;

    calendar_seconds_converter u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_in_year     (s_in_year),
        .s_in_month    (s_in_month),
        .s_in_day      (s_in_day),
        .s_in_hour     (s_in_hour),
        .s_in_minute   (s_in_minute),
        .s_in_second   (s_in_second),
        .s_in_seconds  (s_in_seconds),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_year    (m_out_year),
        .m_out_month   (m_out_month),
        .m_out_day     (m_out_day),
        .m_out_hour    (m_out_hour),
        .m_out_minute  (m_out_minute),
        .m_out_second  (m_out_second),
        .m_out_seconds (m_out_seconds)
    );

    csc_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_in_year     (s_in_year),
        .s_in_month    (s_in_month),
        .s_in_day      (s_in_day),
        .s_in_hour     (s_in_hour),
        .s_in_minute   (s_in_minute),
        .s_in_second   (s_in_second),
        .s_in_seconds  (s_in_seconds),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_year    (m_out_year),
        .m_out_month   (m_out_month),
        .m_out_day     (m_out_day),
        .m_out_hour    (m_out_hour),
        .m_out_minute  (m_out_minute),
        .m_out_second  (m_out_second),
        .m_out_seconds (m_out_seconds),
        .mismatches    (mismatches),
        .outstanding   (pending_results),
        .compared      (results_checked)
    );

    // Receiver: run a pending hold-off first, otherwise stall at random.
    // A new hold starts whenever the stimulus bumps hold_req.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_seen <= hold_req;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still pending",
                     $time, idle_cycles, pending_results);
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Leap-aware month length, used to shape well-formed dates
    function automatic int unsigned month_days(input int unsigned y, input int unsigned mo);
        int unsigned len;
        bit          leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (mo)
            4, 6, 9, 11: len = 30;
            2:           len = leap ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Date-to-seconds item; the unused seconds field carries noise
    function automatic in_item_t date_item(input int unsigned y, input int unsigned mo,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
        in_item_t it;
        it.mode    = 1'b0;
        it.year    = 12'(y);
        it.month   = 4'(mo);
        it.day     = 5'(d);
        it.hour    = 5'(h);
        it.minute  = 6'(mi);
        it.second  = 6'(s);
        it.seconds = $urandom;
        return it;
    endfunction

    // Seconds-to-date item; the unused date fields carry noise
    function automatic in_item_t seconds_item(input logic [31:0] t);
        in_item_t it;
        it = date_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        it.mode    = 1'b1;
        it.seconds = t;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        it   = seconds_item($urandom);
        pick = $urandom_range(0, 99);
        it.mode = 1'($urandom);
        if (!it.mode) begin
            // Mostly well-formed dates, some with one field broken, rest pure noise
            if (pick < 85) begin
                it.year   = 12'($urandom_range(FIRST_YEAR, LAST_YEAR));
                it.month  = 4'($urandom_range(1, 12));
                len       = month_days(it.year, it.month);
                it.day    = 5'($urandom_range(1, len));
                it.hour   = 5'($urandom_range(0, 23));
                it.minute = 6'($urandom_range(0, 59));
                it.second = 6'($urandom_range(0, 59));
                if (pick >= 65) begin
                    case ($urandom_range(0, 5))
                        0: it.year = $urandom_range(0, 1) ? 12'($urandom_range(2101, 4095))
                                                          : 12'($urandom_range(0, 1999));
                        1: it.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
                        2: it.day = (len == 31 || $urandom_range(0, 1)) ? 5'd0
                                  : 5'($urandom_range(len + 1, 31));
                        3: it.hour = 5'($urandom_range(24, 31));
                        4: it.minute = 6'($urandom_range(60, 63));
                        default: it.second = 6'($urandom_range(60, 63));
                    endcase
                end
            end
        end else begin
            // Mostly in-range counts, some on day edges, rest full 32-bit range
            if (pick < 60) begin
                it.seconds = $urandom_range(0, LAST_VALID_SECS);
            end else if (pick < 85) begin
                k = $urandom_range(0, 49709);
                it.seconds = 32'(k * 86400 + ($urandom_range(0, 1) ? 0 : 86399));
            end
        end
        return it;
    endfunction

    // Offer one transfer, with optional idle cycles ahead of it, and return
    // at the edge where it is taken. Valid is left high for the next call.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= it.mode;
        s_in_year    <= it.year;
        s_in_month   <= it.month;
        s_in_day     <= it.day;
        s_in_hour    <= it.hour;
        s_in_minute  <= it.minute;
        s_in_second  <= it.second;
        s_in_seconds <= it.seconds;
        if (it.mode) begin
            n_to_date++;
        end else begin
            n_to_seconds++;
        end
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    initial begin
        idle_phase_t phase;
        int          n;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: range edges, leap rules, each status, field priority
        send_item(date_item(2000, 1, 1, 0, 0, 0));
        send_item(date_item(2100, 12, 31, 23, 59, 59));
        send_item(date_item(2024, 2, 29, 12, 34, 56));
        send_item(date_item(2000, 2, 29, 23, 59, 59));
        send_item(date_item(2100, 2, 29, 0, 0, 0));
        send_item(date_item(2023, 2, 29, 0, 0, 0));
        send_item(date_item(2023, 4, 31, 0, 0, 0));
        send_item(date_item(2023, 1, 0, 0, 0, 0));
        send_item(date_item(1999, 12, 31, 23, 59, 59));
        send_item(date_item(2101, 1, 1, 0, 0, 0));
        send_item(date_item(0, 0, 0, 0, 0, 0));
        send_item(date_item(4095, 15, 31, 31, 63, 63));
        send_item(date_item(2050, 0, 1, 0, 0, 0));
        send_item(date_item(2050, 13, 1, 0, 0, 0));
        send_item(date_item(2050, 15, 31, 31, 63, 63));
        send_item(date_item(2050, 6, 15, 24, 0, 0));
        send_item(date_item(2050, 6, 15, 31, 63, 63));
        send_item(date_item(2050, 6, 15, 23, 60, 0));
        send_item(date_item(2050, 6, 15, 23, 63, 0));
        send_item(date_item(2050, 6, 15, 23, 59, 60));
        send_item(date_item(2050, 6, 15, 23, 59, 63));
        send_item(seconds_item(32'd0));
        send_item(seconds_item(32'd5183999));
        send_item(seconds_item(LAST_VALID_SECS));
        send_item(seconds_item(LAST_VALID_SECS + 32'd1));
        send_item(seconds_item(32'hFFFF_FFFF));
        pause_until_drained();

        // Random phases, each with its own idle pattern; drain between them
        phase = PH_STEADY;
        do begin
            case (phase)
                PH_STEADY: begin
                    sender_idle_pct = 0;
                    rx_stall_pct   <= 0;
                end
                PH_SENDER_GAPS: begin
                    sender_idle_pct = 47;
                    rx_stall_pct   <= 0;
                end
                PH_RECEIVER_STALLS: begin
                    sender_idle_pct = 0;
                    rx_stall_pct   <= 47;
                end
                default: begin
                    sender_idle_pct = 9;
                    rx_stall_pct   <= 9;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Back-pressure the output while the sender keeps offering,
                // so the pipeline fills and s_ready drops
                if ((phase == PH_STEADY || phase == PH_RECEIVER_STALLS) && n == 40) begin
                    hold_req <= hold_req + 1;
                end
                send_item(random_item());
            end
            pause_until_drained();
            phase = phase.next();
        end while (phase != PH_STEADY);

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d date-to-seconds and %0d seconds-to-date transfers, %0d results",
                 n_to_seconds, n_to_date, results_checked);
        $display("summary: steady, sender-gap, receiver-stall and mixed phases, %0d hold-offs",
                 hold_seen);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
